@@ design/rme_pkg.sv @@
// Shared types and constants for the RSA modular exponentiation engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rme_pkg;
  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH + 1);
  localparam int BIT_W = $clog2(WIDTH);
  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_PUB_EXP = 2'd1;
  localparam logic [1:0] REG_PRIV_EXP = 2'd2;

  localparam logic [WIDTH-1:0] RST_MODULUS = WIDTH'(33);
  localparam logic [WIDTH-1:0] RST_PUB_EXP = WIDTH'(3);
  localparam logic [WIDTH-1:0] RST_PRIV_EXP = WIDTH'(7);

  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WIDTH-1:0] prod;
  } mm_stat_t;
endpackage
`default_nettype wire

@@ design/rme_if.sv @@
// Valid/ready channel interfaces for input and result words.
// Depends on rme_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rme_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [rme_pkg::WIDTH-1:0] value;
  modport source (output valid, op, value, input ready);
  modport sink (input valid, op, value, output ready);
endinterface

interface rme_out_if;
  logic                      valid;
  logic                      ready;
  logic [rme_pkg::WIDTH-1:0] residue;
  modport source (output valid, residue, input ready);
  modport sink (input valid, residue, output ready);
endinterface
`default_nettype wire

@@ design/rme_cell.sv @@
// One cell of the multiplier operand line: holds one bit, passes it on.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rme_cell (
  input  wire logic clk,
  input  wire logic load,
  input  wire logic shift,
  input  wire logic load_bit,
  input  wire logic in_bit,
  output logic      q
);
  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_bit;
    end else if (shift) begin
      q <= in_bit;
    end
  end
endmodule
`default_nettype wire

@@ design/rme_mulmod.sv @@
// Interleaved modular multiplier: the multiplier operand runs MSB first
// through a chain of rme_cell; one double-and-add step per cycle.
// Depends on rme_pkg and rme_cell.
`timescale 1ns / 1ps
`default_nettype none
module rme_mulmod (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire rme_pkg::mm_req_t          req,
  input  wire logic [rme_pkg::WIDTH-1:0] m,
  output rme_pkg::mm_stat_t              stat
);
  import rme_pkg::*;

  logic [WIDTH-1:0] chain;
  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [WIDTH:0]   dbl;
  logic [WIDTH:0]   dred;
  logic [WIDTH:0]   sum;
  logic [WIDTH-1:0] acc_next;

  // cell 0 sits at the LSB end; the top cell presents the current bit
  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      rme_cell u_cell (.clk(clk), .load(req.start), .shift(busy),
                       .load_bit(req.b[i]), .in_bit(1'b0), .q(chain[i]));
    end else begin : g_rest
      rme_cell u_cell (.clk(clk), .load(req.start), .shift(busy),
                       .load_bit(req.b[i]), .in_bit(chain[i-1]), .q(chain[i]));
    end
  end

  always_comb begin
    dbl  = {acc, 1'b0};
    dred = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum  = dred + {1'b0, a};
    if (!chain[WIDTH-1]) begin
      acc_next = dred[WIDTH-1:0];
    end else if (sum >= {1'b0, m}) begin
      acc_next = WIDTH'(sum - {1'b0, m});
    end else begin
      acc_next = sum[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a   <= req.a;
      acc <= '0;
    end else if (busy) begin
      acc <= acc_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.prod = acc;
endmodule
`default_nettype wire

@@ design/rsa_modular_exponentiation.sv @@
// Top level: register file, square-and-multiply sequencer, output register.
// Depends on rme_pkg, rme_if, rme_mulmod.
//
//  channel  dir  handshake      payload
//  msg      in   valid/ready    op, value
//  res      out  valid/ready    residue
//  apb      in   psel/penable   modulus, public_exponent, private_exponent
//
// An item runs one reducing multiply, then for each exponent bit, MSB first,
// a squaring and, for a one bit, a multiply; a modulus below 2 gives 0.
// Reset is synchronous and loads n=33, e=3, d=7.
// A result held in the output register blocks the next item until taken.
`timescale 1ns / 1ps
`default_nettype none
module rsa_modular_exponentiation (
  input  wire logic                       clk,
  input  wire logic                       rst,
  rme_in_if.sink                          msg,
  rme_out_if.source                       res,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rme_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import rme_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RED  = 4'b0010,
    S_SQ   = 4'b0100,
    S_ML   = 4'b1000
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] pub_exp;
  logic [WIDTH-1:0] priv_exp;
  logic [WIDTH-1:0] m;
  logic [WIDTH-1:0] expo;
  logic [WIDTH-1:0] base;
  logic [BIT_W-1:0] bit_idx;
  logic             out_valid;
  logic [WIDTH-1:0] residue;
  logic             accept;
  logic             wr;
  mm_req_t          mreq;
  mm_stat_t         mstat;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= RST_MODULUS;
      pub_exp  <= RST_PUB_EXP;
      priv_exp <= RST_PRIV_EXP;
    end else if (wr) begin
      case (paddr[3:2])
        REG_MODULUS:  modulus  <= pwdata;
        REG_PUB_EXP:  pub_exp  <= pwdata;
        REG_PRIV_EXP: priv_exp <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODULUS:  prdata = modulus;
      REG_PUB_EXP:  prdata = pub_exp;
      REG_PRIV_EXP: prdata = priv_exp;
      default:      prdata = '0;
    endcase
  end

  assign msg.ready = (state == S_IDLE) && !out_valid;
  assign accept = msg.valid && msg.ready;
  assign res.valid = out_valid;
  assign res.residue = residue;

  // launch the next multiply in the cycle the sequencer decides on it
  always_comb begin
    mreq.start = 1'b0;
    mreq.a = mstat.prod;
    mreq.b = mstat.prod;
    case (state)
      S_IDLE: begin
        mreq.start = accept && (modulus > WIDTH'(1));
        mreq.a = WIDTH'(1);
        mreq.b = msg.value;
      end
      S_RED: begin
        mreq.start = mstat.done;
        mreq.a = WIDTH'(1);
        mreq.b = WIDTH'(1);
      end
      S_SQ: begin
        mreq.start = mstat.done && (expo[bit_idx] || bit_idx != '0);
        if (expo[bit_idx]) begin
          mreq.b = base;
        end
      end
      S_ML: begin
        mreq.start = mstat.done && bit_idx != '0;
      end
      default: ;
    endcase
  end

  rme_mulmod u_mulmod (.clk(clk), .rst(rst), .req(mreq), .m(m), .stat(mstat));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            m       <= modulus;
            expo    <= msg.op ? priv_exp : pub_exp;
            bit_idx <= BIT_W'(WIDTH - 1);
            if (modulus > WIDTH'(1)) begin
              state <= S_RED;
            end else begin
              residue   <= '0;
              out_valid <= 1'b1;
            end
          end
        end
        S_RED: begin
          if (mstat.done) begin
            base  <= mstat.prod;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (mstat.done) begin
            if (expo[bit_idx]) begin
              state <= S_ML;
            end else if (bit_idx == '0) begin
              residue   <= mstat.prod;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              bit_idx <= bit_idx - 1'b1;
            end
          end
        end
        S_ML: begin
          if (mstat.done) begin
            if (bit_idx == '0) begin
              residue   <= mstat.prod;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              bit_idx <= bit_idx - 1'b1;
              state   <= S_SQ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    mreq.start |-> !mstat.busy)
    else $error("multiply launched while busy");
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    mstat.done |-> (state != S_IDLE))
    else $error("multiply finished with no item in work");
  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    mstat.busy |-> (state == S_RED || state == S_SQ || state == S_ML))
    else $error("multiplier busy while sequencer idle");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |=> (out_valid && $stable(residue)))
    else $error("result word dropped while stalled");
endmodule
`default_nettype wire
